>>> sv/cc_pkg.sv
// Package for the circumcircle block: widths, status codes and the structs
// that travel between the front end, the divider and the back end.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package cc_pkg;

    localparam int COORD_WIDTH = 18;
    localparam int DW    = COORD_WIDTH + 1;      // point differences
    localparam int PW    = 2 * DW;               // products of differences
    localparam int LW    = 2 * DW;               // squared lengths, unsigned
    localparam int DETW  = 2 * DW + 2;           // determinant, signed
    localparam int DMW   = 2 * DW + 1;           // determinant magnitude
    localparam int PPW   = 2 * DW + 1;           // partial products
    localparam int NW    = 3 * DW + 1;           // numerators, signed
    localparam int NMW   = 3 * DW;               // numerator magnitude and quotient
    localparam int CAP_BITS = 40;                // offset magnitude cap is 2^CAP_BITS
    localparam int QW    = (NMW + 1 > CAP_BITS + 2) ? NMW + 1 : CAP_BITS + 2;
    localparam int OFF_W = CAP_BITS + 2;         // signed offset
    localparam int CSW   = OFF_W + 1;            // centre sum before clamping
    localparam int OUT_W = 32;
    localparam int SQW   = 2 * OUT_W;            // radicand
    localparam int SQ_REM_W = OUT_W + 2;
    localparam int SQ_CUR_W = SQ_REM_W + 2;

    localparam logic signed [CSW-1:0] C_MAX = CSW'(2147483647);
    localparam logic signed [CSW-1:0] C_MIN = -C_MAX - CSW'(1);

    typedef enum logic [1:0] {
        ST_VALID = 2'd0,
        ST_DEGEN = 2'd1,
        ST_SAT   = 2'd2
    } t_status;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
    } t_points;

    typedef struct packed {
        logic [NMW-1:0] num;
        logic [DMW-1:0] rem;
        logic [NMW-1:0] quo;
        logic           neg;
    } t_div_lane;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic [DMW-1:0]                dm;
        logic                          degen;
    } t_div_ctx;

    typedef struct packed {
        t_div_ctx  ctx;
        t_div_lane lx;
        t_div_lane ly;
    } t_div_word;

    typedef struct packed {
        logic signed [OUT_W-1:0] center_x;
        logic signed [OUT_W-1:0] center_y;
        logic [OUT_W-1:0]        radius;
        t_status                 status;
    } t_result;

endpackage

`default_nettype wire

>>> sv/cc_if.sv
// Handshake interfaces for the circumcircle block: the point beat in and
// the circle beat out. Depends on cc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface cc_in_if;
    import cc_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [COORD_WIDTH-1:0] ax;
    logic signed [COORD_WIDTH-1:0] ay;
    logic signed [COORD_WIDTH-1:0] bx;
    logic signed [COORD_WIDTH-1:0] by;
    logic signed [COORD_WIDTH-1:0] cx;
    logic signed [COORD_WIDTH-1:0] cy;
    modport source (output valid, ax, ay, bx, by, cx, cy, input ready);
    modport sink   (input valid, ax, ay, bx, by, cx, cy, output ready);
endinterface

interface cc_out_if;
    import cc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] center_x;
    logic signed [OUT_W-1:0] center_y;
    logic [OUT_W-1:0]        radius;
    logic [1:0]              fit_status;
    modport source (output valid, center_x, center_y, radius, fit_status, input ready);
    modport sink   (input valid, center_x, center_y, radius, fit_status, output ready);
endinterface

`default_nettype wire

>>> sv/circumcircle_from_three_points.sv
// Top level of the circumcircle block: front end, divider, back end and the
// output skid register. Depends on cc_pkg, cc_if, cc_front, cc_div, cc_back.
`timescale 1ns / 1ps
`default_nettype none

// Circle through three points. Each input beat carries three points a, b, c in
// signed fixed point; each output beat carries the centre, the truncated
// square-root radius and a status: valid, degenerate (collinear or repeated
// points, or a radius that truncates to zero; all fields are then zero) or
// saturated (an offset beyond 2^40, a centre outside the 32-bit range or a
// radius of 2^32 or more; the clamped values are output). The block is fully
// pipelined: while ready is high one beat is accepted every cycle, and each
// beat gives exactly one result, in order. The divider resolves one quotient
// bit per stage and the square root one radius bit per stage. A stalled output
// beat moves into a one-beat skid register, so the pipeline keeps moving in
// the stall cycle itself; while that register is full, from the next cycle
// until its beat is taken, the whole pipeline holds and ready is low.
module circumcircle_from_three_points (
    input  logic        i_clk,
    input  logic        i_rst_n,
    cc_in_if.sink       i_in,
    cc_out_if.source    o_out
);
    import cc_pkg::*;

    logic      w_en;
    logic      w_fv;
    t_points   w_pts;
    t_div_word w_fword;
    logic      w_dv;
    t_div_word w_dword;
    logic      w_bv;
    t_result   w_bres;

    logic      r_skid_v;
    t_result   r_skid;
    t_result   w_out;

    // The pipeline moves whenever the skid register is empty.
    assign w_en       = !r_skid_v;
    assign i_in.ready = w_en;

    assign w_pts.ax = i_in.ax;
    assign w_pts.ay = i_in.ay;
    assign w_pts.bx = i_in.bx;
    assign w_pts.by = i_in.by;
    assign w_pts.cx = i_in.cx;
    assign w_pts.cy = i_in.cy;

    cc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_in.valid),
        .i_pts   (w_pts),
        .o_valid (w_fv),
        .o_word  (w_fword)
    );

    cc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_fv),
        .i_word  (w_fword),
        .o_valid (w_dv),
        .o_word  (w_dword)
    );

    cc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_dv),
        .i_word  (w_dword),
        .o_valid (w_bv),
        .o_res   (w_bres)
    );

    // The skid register takes the last stage's beat when the sink stalls while
    // the pipeline is moving; it is always older than what the pipeline holds.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (o_out.ready) begin
                r_skid_v <= 1'b0;
            end
        end else if (w_bv && !o_out.ready) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_skid_v && w_bv && !o_out.ready) begin
            r_skid <= w_bres;
        end
    end

    assign w_out            = r_skid_v ? r_skid : w_bres;
    assign o_out.valid      = r_skid_v | w_bv;
    assign o_out.center_x   = w_out.center_x;
    assign o_out.center_y   = w_out.center_y;
    assign o_out.radius     = w_out.radius;
    assign o_out.fit_status = w_out.status;

    // The skid register fills only from a stalled output beat.
    a_skid_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_skid_v) |-> $past(w_bv && !o_out.ready))
        else $error("skid register filled without a stalled output beat");

    // No input beat is taken while the skid register is full.
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v |-> !i_in.ready)
        else $error("input accepted while the pipeline is held");

    // A held skid beat keeps its contents until it is taken.
    a_skid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_v && !o_out.ready |=> r_skid_v && $stable(r_skid))
        else $error("skid beat lost or changed while stalled");

    // A degenerate result carries zero fields.
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.fit_status == ST_DEGEN |->
            o_out.center_x == '0 && o_out.center_y == '0 && o_out.radius == '0)
        else $error("degenerate result with nonzero fields");

endmodule

`default_nettype wire

>>> sv/cc_front.sv
// Front end: differences, determinant, squared lengths and exact centre
// numerators over seven stages. Depends on cc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  cc_pkg::t_points    i_pts,
    output logic               o_valid,
    output cc_pkg::t_div_word  o_word
);
    import cc_pkg::*;

    logic [6:0] r_v;

    // stage 1
    logic signed [COORD_WIDTH-1:0] r1_ax, r1_ay;
    logic signed [DW-1:0]          r1_px, r1_py, r1_qx, r1_qy;
    // stage 2
    logic signed [COORD_WIDTH-1:0] r2_ax, r2_ay;
    logic signed [DW-1:0]          r2_px, r2_py, r2_qx, r2_qy;
    logic signed [PW-1:0]          r2_m_pq, r2_m_yx, r2_s_px, r2_s_py, r2_s_qx, r2_s_qy;
    // stage 3
    logic signed [COORD_WIDTH-1:0] r3_ax, r3_ay;
    logic signed [DW-1:0]          r3_px, r3_py, r3_qx, r3_qy;
    logic signed [DETW-1:0]        r3_d;
    logic [LW-1:0]                 r3_lb, r3_lc;
    // stage 4
    logic signed [COORD_WIDTH-1:0] r4_ax, r4_ay;
    logic [DMW-1:0]                r4_dm;
    logic                          r4_dneg, r4_degen;
    logic signed [PPW-1:0]         r4_qylb_lo, r4_qylb_hi, r4_pylc_lo, r4_pylc_hi;
    logic signed [PPW-1:0]         r4_pxlc_lo, r4_pxlc_hi, r4_qxlb_lo, r4_qxlb_hi;
    // stage 5
    logic signed [COORD_WIDTH-1:0] r5_ax, r5_ay;
    logic [DMW-1:0]                r5_dm;
    logic                          r5_dneg, r5_degen;
    logic signed [NW-1:0]          r5_qylb, r5_pylc, r5_pxlc, r5_qxlb;
    // stage 6
    logic signed [COORD_WIDTH-1:0] r6_ax, r6_ay;
    logic [DMW-1:0]                r6_dm;
    logic                          r6_dneg, r6_degen;
    logic signed [NW-1:0]          r6_nx, r6_ny;
    // stage 7
    t_div_word                     r7_word;

    logic signed [DETW-1:0] n3_d;
    logic signed [PPW-1:0]  n4_lb_lo, n4_lb_hi, n4_lc_lo, n4_lc_hi;

    always_comb begin
        n3_d     = (DETW'(r2_m_pq) - DETW'(r2_m_yx)) <<< 1;
        n4_lb_lo = PPW'($signed({1'b0, r3_lb[DW-1:0]}));
        n4_lb_hi = PPW'($signed({1'b0, r3_lb[LW-1:DW]}));
        n4_lc_lo = PPW'($signed({1'b0, r3_lc[DW-1:0]}));
        n4_lc_hi = PPW'($signed({1'b0, r3_lc[LW-1:DW]}));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax <= i_pts.ax;
            r1_ay <= i_pts.ay;
            r1_px <= DW'(i_pts.bx) - DW'(i_pts.ax);
            r1_py <= DW'(i_pts.by) - DW'(i_pts.ay);
            r1_qx <= DW'(i_pts.cx) - DW'(i_pts.ax);
            r1_qy <= DW'(i_pts.cy) - DW'(i_pts.ay);

            r2_ax   <= r1_ax;
            r2_ay   <= r1_ay;
            r2_px   <= r1_px;
            r2_py   <= r1_py;
            r2_qx   <= r1_qx;
            r2_qy   <= r1_qy;
            r2_m_pq <= PW'(r1_px) * PW'(r1_qy);
            r2_m_yx <= PW'(r1_py) * PW'(r1_qx);
            r2_s_px <= PW'(r1_px) * PW'(r1_px);
            r2_s_py <= PW'(r1_py) * PW'(r1_py);
            r2_s_qx <= PW'(r1_qx) * PW'(r1_qx);
            r2_s_qy <= PW'(r1_qy) * PW'(r1_qy);

            r3_ax <= r2_ax;
            r3_ay <= r2_ay;
            r3_px <= r2_px;
            r3_py <= r2_py;
            r3_qx <= r2_qx;
            r3_qy <= r2_qy;
            r3_d  <= n3_d;
            r3_lb <= $unsigned(r2_s_px) + $unsigned(r2_s_py);
            r3_lc <= $unsigned(r2_s_qx) + $unsigned(r2_s_qy);

            r4_ax      <= r3_ax;
            r4_ay      <= r3_ay;
            r4_dneg    <= r3_d[DETW-1];
            r4_degen   <= (r3_d == '0);
            r4_dm      <= r3_d[DETW-1] ? DMW'(-r3_d) : DMW'(r3_d);
            r4_qylb_lo <= PPW'(r3_qy) * n4_lb_lo;
            r4_qylb_hi <= PPW'(r3_qy) * n4_lb_hi;
            r4_pylc_lo <= PPW'(r3_py) * n4_lc_lo;
            r4_pylc_hi <= PPW'(r3_py) * n4_lc_hi;
            r4_pxlc_lo <= PPW'(r3_px) * n4_lc_lo;
            r4_pxlc_hi <= PPW'(r3_px) * n4_lc_hi;
            r4_qxlb_lo <= PPW'(r3_qx) * n4_lb_lo;
            r4_qxlb_hi <= PPW'(r3_qx) * n4_lb_hi;

            r5_ax    <= r4_ax;
            r5_ay    <= r4_ay;
            r5_dm    <= r4_dm;
            r5_dneg  <= r4_dneg;
            r5_degen <= r4_degen;
            r5_qylb  <= (NW'(r4_qylb_hi) <<< DW) + NW'(r4_qylb_lo);
            r5_pylc  <= (NW'(r4_pylc_hi) <<< DW) + NW'(r4_pylc_lo);
            r5_pxlc  <= (NW'(r4_pxlc_hi) <<< DW) + NW'(r4_pxlc_lo);
            r5_qxlb  <= (NW'(r4_qxlb_hi) <<< DW) + NW'(r4_qxlb_lo);

            r6_ax    <= r5_ax;
            r6_ay    <= r5_ay;
            r6_dm    <= r5_dm;
            r6_dneg  <= r5_dneg;
            r6_degen <= r5_degen;
            r6_nx    <= r5_qylb - r5_pylc;
            r6_ny    <= r5_pxlc - r5_qxlb;

            r7_word.ctx.ax    <= r6_ax;
            r7_word.ctx.ay    <= r6_ay;
            r7_word.ctx.dm    <= r6_dm;
            r7_word.ctx.degen <= r6_degen;
            r7_word.lx.num    <= r6_nx[NW-1] ? NMW'(-r6_nx) : NMW'(r6_nx);
            r7_word.lx.neg    <= r6_nx[NW-1] ^ r6_dneg;
            r7_word.lx.rem    <= '0;
            r7_word.lx.quo    <= '0;
            r7_word.ly.num    <= r6_ny[NW-1] ? NMW'(-r6_ny) : NMW'(r6_ny);
            r7_word.ly.neg    <= r6_ny[NW-1] ^ r6_dneg;
            r7_word.ly.rem    <= '0;
            r7_word.ly.quo    <= '0;
        end
    end

    assign o_valid = r_v[6];
    assign o_word  = r7_word;

endmodule

`default_nettype wire

>>> sv/cc_div.sv
// Pipelined restoring divider, one quotient bit per stage, two lanes that
// share the divisor. Depends on cc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  cc_pkg::t_div_word  i_word,
    output logic               o_valid,
    output cc_pkg::t_div_word  o_word
);
    import cc_pkg::*;

    function automatic t_div_lane div_step(t_div_lane l, logic [DMW-1:0] dm, int bit_pos);
        logic [DMW:0] cur;
        t_div_lane    o;
        o   = l;
        cur = {l.rem, l.num[bit_pos]};
        if (cur >= {1'b0, dm}) begin
            o.rem          = DMW'(cur - {1'b0, dm});
            o.quo[bit_pos] = 1'b1;
        end else begin
            o.rem = DMW'(cur);
        end
        return o;
    endfunction

    t_div_word r_w [NMW];
    t_div_word n_w [NMW];
    logic      r_v [NMW];

    for (genvar j = 0; j < NMW; j++) begin : g_stage
        t_div_word src;
        logic      src_v;
        if (j == 0) begin : g_first
            assign src   = i_word;
            assign src_v = i_valid;
        end else begin : g_next
            assign src   = r_w[j-1];
            assign src_v = r_v[j-1];
        end

        always_comb begin
            n_w[j]     = src;
            n_w[j].lx  = div_step(src.lx, src.ctx.dm, NMW - 1 - j);
            n_w[j].ly  = div_step(src.ly, src.ctx.dm, NMW - 1 - j);
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_w[j] <= n_w[j];
            end
        end
    end

    assign o_valid = r_v[NMW-1];
    assign o_word  = r_w[NMW-1];

endmodule

`default_nettype wire

>>> sv/cc_back.sv
// Back end: quotient rounding and capping, centre sums and clamping, radius
// squares, a bit-pair square root pipeline and the final result. Depends on cc_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  cc_pkg::t_div_word  i_word,
    output logic               o_valid,
    output cc_pkg::t_result    o_res
);
    import cc_pkg::*;

    typedef struct packed {
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    sat;
        logic                    ovf;
        logic                    degen;
    } t_sq_ctx;

    typedef struct packed {
        t_sq_ctx               ctx;
        logic [SQW-1:0]        rad;
        logic [SQ_REM_W-1:0]   rem;
        logic [OUT_W-1:0]      root;
    } t_sq_word;

    localparam logic [QW-1:0] CAP = QW'(1) << CAP_BITS;

    logic [3:0] r_v;

    // stage 1: rounding and cap
    logic signed [COORD_WIDTH-1:0] r1_ax, r1_ay;
    logic [CAP_BITS:0]             r1_qx, r1_qy;
    logic                          r1_negx, r1_negy, r1_sat, r1_degen;
    // stage 2: signed offsets and squares
    logic signed [COORD_WIDTH-1:0] r2_ax, r2_ay;
    logic signed [OFF_W-1:0]       r2_ox, r2_oy;
    logic [SQW-1:0]                r2_sqx, r2_sqy;
    logic                          r2_big, r2_sat, r2_degen;
    // stage 3: radicand and centre sums
    logic signed [CSW-1:0]         r3_csx, r3_csy;
    logic [SQW-1:0]                r3_rad;
    logic                          r3_ovf, r3_sat, r3_degen;
    // stage 4: clamping, root pipeline entry
    t_sq_word                      r4_w;

    logic              n1_upx, n1_upy, n1_capx, n1_capy;
    logic [QW-1:0]     n1_qx, n1_qy;
    logic [SQW:0]      n3_sum;
    logic              n4_hix, n4_lox, n4_hiy, n4_loy;

    always_comb begin
        n1_upx  = {i_word.lx.rem, 1'b0} >= {1'b0, i_word.ctx.dm};
        n1_upy  = {i_word.ly.rem, 1'b0} >= {1'b0, i_word.ctx.dm};
        n1_qx   = QW'(i_word.lx.quo) + QW'(n1_upx);
        n1_qy   = QW'(i_word.ly.quo) + QW'(n1_upy);
        n1_capx = n1_qx > CAP;
        n1_capy = n1_qy > CAP;
        n3_sum  = (SQW+1)'(r2_sqx) + (SQW+1)'(r2_sqy);
        n4_hix  = r3_csx > C_MAX;
        n4_lox  = r3_csx < C_MIN;
        n4_hiy  = r3_csy > C_MAX;
        n4_loy  = r3_csy < C_MIN;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_ax    <= i_word.ctx.ax;
            r1_ay    <= i_word.ctx.ay;
            r1_negx  <= i_word.lx.neg;
            r1_negy  <= i_word.ly.neg;
            r1_degen <= i_word.ctx.degen;
            r1_qx    <= n1_capx ? CAP[CAP_BITS:0] : n1_qx[CAP_BITS:0];
            r1_qy    <= n1_capy ? CAP[CAP_BITS:0] : n1_qy[CAP_BITS:0];
            r1_sat   <= n1_capx | n1_capy;

            r2_ax    <= r1_ax;
            r2_ay    <= r1_ay;
            r2_ox    <= r1_negx ? -$signed(OFF_W'(r1_qx)) : $signed(OFF_W'(r1_qx));
            r2_oy    <= r1_negy ? -$signed(OFF_W'(r1_qy)) : $signed(OFF_W'(r1_qy));
            r2_sqx   <= SQW'(r1_qx[OUT_W-1:0]) * SQW'(r1_qx[OUT_W-1:0]);
            r2_sqy   <= SQW'(r1_qy[OUT_W-1:0]) * SQW'(r1_qy[OUT_W-1:0]);
            r2_big   <= (|r1_qx[CAP_BITS:OUT_W]) | (|r1_qy[CAP_BITS:OUT_W]);
            r2_sat   <= r1_sat;
            r2_degen <= r1_degen;

            r3_csx   <= CSW'(r2_ax) + CSW'(r2_ox);
            r3_csy   <= CSW'(r2_ay) + CSW'(r2_oy);
            r3_rad   <= n3_sum[SQW-1:0];
            r3_ovf   <= n3_sum[SQW] | r2_big;
            r3_sat   <= r2_sat;
            r3_degen <= r2_degen;

            r4_w.ctx.cx    <= n4_hix ? C_MAX[OUT_W-1:0] :
                              (n4_lox ? C_MIN[OUT_W-1:0] : r3_csx[OUT_W-1:0]);
            r4_w.ctx.cy    <= n4_hiy ? C_MAX[OUT_W-1:0] :
                              (n4_loy ? C_MIN[OUT_W-1:0] : r3_csy[OUT_W-1:0]);
            r4_w.ctx.sat   <= r3_sat | r3_ovf | n4_hix | n4_lox | n4_hiy | n4_loy;
            r4_w.ctx.ovf   <= r3_ovf;
            r4_w.ctx.degen <= r3_degen;
            r4_w.rad       <= r3_rad;
            r4_w.rem       <= '0;
            r4_w.root      <= '0;
        end
    end

    // Square root, one result bit per stage.
    function automatic t_sq_word sq_step(t_sq_word w);
        logic [SQ_CUR_W-1:0] cur;
        logic [SQ_CUR_W-1:0] trial;
        t_sq_word            o;
        o     = w;
        cur   = {w.rem, w.rad[SQW-1:SQW-2]};
        trial = SQ_CUR_W'({w.root, 2'b01});
        if (cur >= trial) begin
            o.rem  = SQ_REM_W'(cur - trial);
            o.root = {w.root[OUT_W-2:0], 1'b1};
        end else begin
            o.rem  = SQ_REM_W'(cur);
            o.root = {w.root[OUT_W-2:0], 1'b0};
        end
        o.rad = w.rad << 2;
        return o;
    endfunction

    t_sq_word r_sq [OUT_W];
    logic     r_sv [OUT_W];

    for (genvar k = 0; k < OUT_W; k++) begin : g_sq
        t_sq_word src;
        logic     src_v;
        if (k == 0) begin : g_first
            assign src   = r4_w;
            assign src_v = r_v[3];
        end else begin : g_next
            assign src   = r_sq[k-1];
            assign src_v = r_sv[k-1];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sv[k] <= 1'b0;
            end else if (i_en) begin
                r_sv[k] <= src_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[k] <= sq_step(src);
            end
        end
    end

    // Final stage.
    t_sq_word n_fin;
    t_result  n_res;
    t_result  r_res;
    logic     r_fv;

    always_comb begin
        n_fin = r_sq[OUT_W-1];
        if (n_fin.ctx.degen || (!n_fin.ctx.ovf && n_fin.root == '0)) begin
            n_res.center_x = '0;
            n_res.center_y = '0;
            n_res.radius   = '0;
            n_res.status   = ST_DEGEN;
        end else begin
            n_res.center_x = n_fin.ctx.cx;
            n_res.center_y = n_fin.ctx.cy;
            n_res.radius   = n_fin.ctx.ovf ? '1 : n_fin.root;
            n_res.status   = n_fin.ctx.sat ? ST_SAT : ST_VALID;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fv <= 1'b0;
        end else if (i_en) begin
            r_fv <= r_sv[OUT_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
        end
    end

    assign o_valid = r_fv;
    assign o_res   = r_res;

endmodule

`default_nettype wire
